### hdl/krt_pkg.sv
// Shared types and constants for the keyed record table.
package krt_pkg;

    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int KEY_W   = 31;
    localparam int NAME_W  = 64;
    localparam int SCORE_W = 16;
    localparam int SUM_W   = 22;
    localparam int COUNT_W = 7;

    localparam logic signed [SCORE_W-1:0] SCORE_LOWEST  = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_HIGHEST = {1'b0, {(SCORE_W-1){1'b1}}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_DEL   = 3'd1,
        OP_FIND  = 3'd2,
        OP_UPD   = 3'd3,
        OP_LIST  = 3'd4,
        OP_STATS = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_SHIFT,
        S_WALK,
        S_STATS,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [NAME_W-1:0]         name;
        logic signed [SCORE_W-1:0] score;
    } t_rec;

    typedef struct packed {
        logic    load;
        logic    step;
        logic    init_shift;
        logic    shift_wr;
        logic    append;
        logic    upd;
        logic    dec;
        logic    emit;
        t_status status;
        logic    with_rec;
        logic    with_stats;
        logic    last;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hit;
        logic more;
        logic rd_vld;
        logic exhausted;
        logic empty;
        logic full;
        logic out_free;
    } t_sts;

endpackage

### hdl/krt_ctrl.sv
// Sequencer for the keyed record table: decodes each operation and steps the datapath.
module krt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  krt_pkg::t_sts i_sts,
    output krt_pkg::t_cmd o_cmd
);

    krt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = krt_pkg::ST_DONE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            krt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = krt_pkg::S_DISPATCH;
                end
            end
            krt_pkg::S_DISPATCH: begin
                unique case (i_sts.op) inside
                    krt_pkg::OP_ADD, krt_pkg::OP_DEL, krt_pkg::OP_FIND, krt_pkg::OP_UPD:
                        n_state = krt_pkg::S_SCAN;
                    krt_pkg::OP_LIST:
                        n_state = i_sts.empty ? krt_pkg::S_EMPTY : krt_pkg::S_WALK;
                    krt_pkg::OP_STATS:
                        n_state = i_sts.empty ? krt_pkg::S_EMPTY : krt_pkg::S_STATS;
                    default:
                        n_state = krt_pkg::S_IDLE;
                endcase
            end
            krt_pkg::S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = krt_pkg::S_HIT;
                end else if (i_sts.exhausted) begin
                    n_state = krt_pkg::S_MISS;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            krt_pkg::S_HIT: begin
                unique case (i_sts.op)
                    krt_pkg::OP_ADD: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = krt_pkg::ST_EXISTS;
                            o_cmd.last   = 1'b1;
                            n_state      = krt_pkg::S_IDLE;
                        end
                    end
                    krt_pkg::OP_FIND: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.with_rec = 1'b1;
                            o_cmd.last     = 1'b1;
                            n_state        = krt_pkg::S_IDLE;
                        end
                    end
                    krt_pkg::OP_UPD: begin
                        if (i_sts.out_free) begin
                            o_cmd.upd  = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            n_state    = krt_pkg::S_IDLE;
                        end
                    end
                    krt_pkg::OP_DEL: begin
                        o_cmd.init_shift = 1'b1;
                        n_state          = krt_pkg::S_SHIFT;
                    end
                    default: n_state = krt_pkg::S_IDLE;
                endcase
            end
            krt_pkg::S_MISS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = krt_pkg::S_IDLE;
                    if (i_sts.op == krt_pkg::OP_ADD) begin
                        if (i_sts.full) begin
                            o_cmd.status = krt_pkg::ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end else begin
                        o_cmd.status = krt_pkg::ST_MISSING;
                    end
                end
            end
            krt_pkg::S_SHIFT: begin
                // move every record above the hole down by one slot
                if (i_sts.exhausted) begin
                    if (i_sts.out_free) begin
                        o_cmd.dec  = 1'b1;
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        n_state    = krt_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.step     = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            krt_pkg::S_WALK: begin
                if (i_sts.rd_vld) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.with_rec = 1'b1;
                        o_cmd.last     = !i_sts.more;
                        o_cmd.step     = 1'b1;
                        if (!i_sts.more) begin
                            n_state = krt_pkg::S_IDLE;
                        end
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            krt_pkg::S_STATS: begin
                if (i_sts.exhausted) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.with_stats = 1'b1;
                        o_cmd.last       = 1'b1;
                        n_state          = krt_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            krt_pkg::S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = krt_pkg::ST_EMPTY;
                    o_cmd.last   = 1'b1;
                    n_state      = krt_pkg::S_IDLE;
                end
            end
            default: n_state = krt_pkg::S_IDLE;
        endcase
    end

endmodule

### hdl/krt_dp.sv
// Datapath for the keyed record table: record memory, scan pointer, statistics and result register.
module krt_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [krt_pkg::OP_W-1:0]             i_opcode,
    input  logic [krt_pkg::KEY_W-1:0]            i_key,
    input  logic [krt_pkg::NAME_W-1:0]           i_name_bytes,
    input  logic signed [krt_pkg::SCORE_W-1:0]   i_score,
    input  krt_pkg::t_cmd                        i_cmd,
    output krt_pkg::t_sts                        o_sts,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [krt_pkg::STAT_W-1:0]           o_status,
    output logic [krt_pkg::KEY_W-1:0]            o_rec_key,
    output logic [krt_pkg::NAME_W-1:0]           o_rec_name,
    output logic signed [krt_pkg::SCORE_W-1:0]   o_rec_score,
    output logic [krt_pkg::COUNT_W-1:0]          o_entry_count,
    output logic signed [krt_pkg::SUM_W-1:0]     o_score_sum,
    output logic signed [krt_pkg::SCORE_W-1:0]   o_score_max,
    output logic signed [krt_pkg::SCORE_W-1:0]   o_score_min,
    output logic                                 o_last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // slot 0 holds the oldest record; the newest sits at r_cnt - 1
    krt_pkg::t_rec r_mem [TABLE_DEPTH];

    krt_pkg::t_op                        r_op;
    logic [krt_pkg::KEY_W-1:0]           r_key;
    logic [krt_pkg::NAME_W-1:0]          r_name;
    logic signed [krt_pkg::SCORE_W-1:0]  r_score;
    logic [CW-1:0]                       r_cnt;
    logic [CW-1:0]                       r_idx;
    logic                                r_rd_vld;
    logic [IW-1:0]                       r_rd_addr;
    krt_pkg::t_rec                       r_rd_rec;
    logic signed [krt_pkg::SUM_W-1:0]    r_sum;
    logic signed [krt_pkg::SCORE_W-1:0]  r_max;
    logic signed [krt_pkg::SCORE_W-1:0]  r_min;
    logic                                r_out_valid;
    krt_pkg::t_status                    r_status;
    krt_pkg::t_rec                       r_out_rec;
    logic [krt_pkg::COUNT_W-1:0]         r_out_count;
    logic signed [krt_pkg::SUM_W-1:0]    r_out_sum;
    logic signed [krt_pkg::SCORE_W-1:0]  r_out_max;
    logic signed [krt_pkg::SCORE_W-1:0]  r_out_min;
    logic                                r_out_last;

    logic          w_more;
    logic [IW-1:0] w_rd_addr;
    logic          w_out_free;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_addr;
    krt_pkg::t_rec w_wr_data;
    logic          w_acc;

    assign w_more     = r_idx < r_cnt;
    // list walks newest first, every other pass walks upward
    assign w_rd_addr  = (r_op == krt_pkg::OP_LIST) ? IW'(r_cnt - r_idx - CW'(1)) : IW'(r_idx);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_acc      = i_cmd.step && r_rd_vld;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_rd_addr;
        w_wr_data = r_rd_rec;
        if (i_cmd.shift_wr && r_rd_vld) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_rd_addr - IW'(1);
        end else if (i_cmd.append) begin
            w_wr_en   = 1'b1;
            w_wr_addr = IW'(r_cnt);
            w_wr_data = '{key: r_key, name: r_name, score: r_score};
        end else if (i_cmd.upd) begin
            w_wr_en         = 1'b1;
            w_wr_data.score = r_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.step && w_more) begin
            r_rd_rec  <= r_mem[w_rd_addr];
            r_rd_addr <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.init_shift) begin
                r_idx    <= CW'(r_rd_addr) + CW'(1);
                r_rd_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_rd_vld <= w_more;
                if (w_more) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (i_cmd.append) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= krt_pkg::t_op'(i_opcode);
            r_key   <= i_key;
            r_name  <= i_name_bytes;
            r_score <= i_score;
            r_sum   <= '0;
            r_max   <= krt_pkg::SCORE_LOWEST;
            r_min   <= krt_pkg::SCORE_HIGHEST;
        end else if (w_acc) begin
            r_sum <= r_sum + krt_pkg::SUM_W'($signed(r_rd_rec.score));
            if ($signed(r_rd_rec.score) > r_max) begin
                r_max <= r_rd_rec.score;
            end
            if ($signed(r_rd_rec.score) < r_min) begin
                r_min <= r_rd_rec.score;
            end
        end
        if (i_cmd.emit) begin
            r_status    <= i_cmd.status;
            r_out_rec   <= i_cmd.with_rec ? r_rd_rec : '0;
            r_out_count <= i_cmd.with_stats ? krt_pkg::COUNT_W'(r_cnt) : '0;
            r_out_sum   <= i_cmd.with_stats ? r_sum : '0;
            r_out_max   <= i_cmd.with_stats ? r_max : '0;
            r_out_min   <= i_cmd.with_stats ? r_min : '0;
            r_out_last  <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.hit       = r_rd_vld && (r_rd_rec.key == r_key);
        o_sts.more      = w_more;
        o_sts.rd_vld    = r_rd_vld;
        o_sts.exhausted = !r_rd_vld && !w_more;
        o_sts.empty     = (r_cnt == '0);
        o_sts.full      = (r_cnt == CW'(TABLE_DEPTH));
        o_sts.out_free  = w_out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_rec_key     = r_out_rec.key;
    assign o_rec_name    = r_out_rec.name;
    assign o_rec_score   = r_out_rec.score;
    assign o_entry_count = r_out_count;
    assign o_score_sum   = r_out_sum;
    assign o_score_max   = r_out_max;
    assign o_score_min   = r_out_min;
    assign o_last        = r_out_last;

endmodule

### hdl/keyed_record_table.sv
// Top level of the keyed record table.
// Holds up to TABLE_DEPTH records of key, 8-byte name and signed score in one single-port-read
// record memory, listed newest first. Every operation takes one beat and is worked on alone:
// add, find, update, delete and stats scan the memory at one entry per cycle (a hit stops the
// scan early); delete then moves each record newer than the removed one down by one slot to
// close the gap; list gives one result beat per cycle while the consumer keeps ready high. The
// read port of the record memory sets these rates. The last result of an item waits in an output
// register while the next item is taken. No clearing pass runs after reset: the record count
// starts at zero.
module keyed_record_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [krt_pkg::OP_W-1:0]             i_opcode,
    input  logic [krt_pkg::KEY_W-1:0]            i_key,
    input  logic [krt_pkg::NAME_W-1:0]           i_name_bytes,
    input  logic signed [krt_pkg::SCORE_W-1:0]   i_score,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [krt_pkg::STAT_W-1:0]           o_status,
    output logic [krt_pkg::KEY_W-1:0]            o_rec_key,
    output logic [krt_pkg::NAME_W-1:0]           o_rec_name,
    output logic signed [krt_pkg::SCORE_W-1:0]   o_rec_score,
    output logic [krt_pkg::COUNT_W-1:0]          o_entry_count,
    output logic signed [krt_pkg::SUM_W-1:0]     o_score_sum,
    output logic signed [krt_pkg::SCORE_W-1:0]   o_score_max,
    output logic signed [krt_pkg::SCORE_W-1:0]   o_score_min,
    output logic                                 o_last
);

    krt_pkg::t_cmd w_cmd;
    krt_pkg::t_sts w_sts;

    krt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    krt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_name_bytes  (i_name_bytes),
        .i_score       (i_score),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_rec_key     (o_rec_key),
        .o_rec_name    (o_rec_name),
        .o_rec_score   (o_rec_score),
        .o_entry_count (o_entry_count),
        .o_score_sum   (o_score_sum),
        .o_score_max   (o_score_max),
        .o_score_min   (o_score_min),
        .o_last        (o_last)
    );

endmodule

### hdl/krt_chk.sv
// Port-level checks for the keyed record table, bound to the top level.
module krt_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [krt_pkg::OP_W-1:0]             i_opcode,
    input logic [krt_pkg::KEY_W-1:0]            i_key,
    input logic [krt_pkg::NAME_W-1:0]           i_name_bytes,
    input logic signed [krt_pkg::SCORE_W-1:0]   i_score,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [krt_pkg::STAT_W-1:0]           o_status,
    input logic [krt_pkg::KEY_W-1:0]            o_rec_key,
    input logic [krt_pkg::NAME_W-1:0]           o_rec_name,
    input logic signed [krt_pkg::SCORE_W-1:0]   o_rec_score,
    input logic [krt_pkg::COUNT_W-1:0]          o_entry_count,
    input logic signed [krt_pkg::SUM_W-1:0]     o_score_sum,
    input logic signed [krt_pkg::SCORE_W-1:0]   o_score_max,
    input logic signed [krt_pkg::SCORE_W-1:0]   o_score_min,
    input logic                                 o_last
);

    // one item at a time: an accepted beat drops ready in the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on back-to-back cycles");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_rec_key)
            && $stable(o_last))
        else $error("result beat changed while stalled");

    // every failure status ends its item and carries no record or statistics
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != krt_pkg::ST_DONE |->
            o_last && o_rec_key == '0 && o_rec_name == '0 && o_entry_count == '0
            && o_score_sum == '0)
        else $error("failure result with payload or without last");

    // statistics over a non-empty table keep max at or above min
    a_stats_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == krt_pkg::ST_DONE && o_entry_count != '0 |->
            o_score_max >= o_score_min && o_last)
        else $error("statistics with max below min");

    // no result appears while the block sits waiting for an item with nothing in flight
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && o_in_ready && !i_in_valid |=> !o_out_valid)
        else $error("result beat without an item");

endmodule

bind keyed_record_table krt_chk u_krt_chk (.*);
